### hdl/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int CELL_BITS = 8;
	localparam int MAX_SCALE = 6;
	localparam int MAX_GAP = 255;
	localparam int CW_W = $clog2(CELL_BITS * MAX_SCALE + 1);
	localparam int LP_W = $clog2(CELL_BITS * MAX_SCALE + MAX_GAP + 1);
	localparam int POS_W = 16;
	localparam int CNT_W = $clog2(POS_W + 1);

	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_SP = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam int TAB_CELLS_LOG2 = 2;

	typedef enum logic [2:0] {
		FN_DRAW_CURSOR = 3'd0,
		FN_DRAW_POINT = 3'd1,
		FN_SET_LINE = 3'd2,
		FN_SET_COLUMN = 3'd3,
		FN_HOME = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_GLYPH_SCALE = 2'd2,
		REG_LINE_GAP = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DY_GO,
		ST_DY_RUN,
		ST_DX_GO,
		ST_DX_RUN,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [2:0] glyph_scale;
		logic [7:0] line_gap;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_start;
		logic div_sel_x;
		logic latch_line;
		logic latch_col;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

### hdl/tcc_div.sv
`timescale 1ns / 1ps

module tcc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [tcc_pkg::POS_W-1:0] dividend,
	input logic [tcc_pkg::LP_W-1:0] divisor,
	output logic done,
	output logic [tcc_pkg::POS_W-1:0] quotient
);
	import tcc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] quo_q;
	logic [LP_W-1:0] rem_q;
	logic [LP_W-1:0] div_q;
	logic [LP_W:0] shifted;
	logic [LP_W:0] trial;

	assign shifted = {rem_q, quo_q[POS_W-1]};
	assign trial = shifted - {1'b0, div_q};
	assign done = (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(POS_W);
		end else if (!done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (!done) begin
			if (!trial[LP_W]) begin
				rem_q <= trial[LP_W-1:0];
				quo_q <= {quo_q[POS_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[LP_W-1:0];
				quo_q <= {quo_q[POS_W-2:0], 1'b0};
			end
		end
	end

endmodule

### hdl/tcc_datapath.sv
`timescale 1ns / 1ps

module tcc_datapath (
	input logic clk,
	input logic arst_n,
	input tcc_pkg::cfg_t cfg,
	input tcc_pkg::cmd_t cmd,
	output tcc_pkg::sts_t sts,
	input logic [2:0] in_func,
	input logic [7:0] in_char_code,
	input logic in_wrap_enable,
	input logic [11:0] in_point_x,
	input logic [11:0] in_point_y,
	input logic [11:0] in_line_or_column,
	output logic out_valid,
	input logic out_ready,
	output logic out_glyph_valid,
	output logic [7:0] out_glyph_code,
	output logic [15:0] out_glyph_x,
	output logic [15:0] out_glyph_y,
	output logic [15:0] out_cursor_line,
	output logic [15:0] out_cursor_column
);
	import tcc_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic valid;
		logic [7:0] code;
	} draw_t;

	function automatic logic [POS_W-1:0] sat16(input logic [POS_W:0] v);
		return v[POS_W] ? '1 : v[POS_W-1:0];
	endfunction

	function automatic draw_t draw_one(
		input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y,
		input logic [7:0] c,
		input logic wrap,
		input logic [CW_W-1:0] cw,
		input logic [LP_W-1:0] lp,
		input logic [11:0] sw,
		input logic [11:0] sh
	);
		draw_t r;
		logic [POS_W-1:0] x2;
		logic [POS_W-1:0] y2;
		logic [7:0] c2;
		logic del;
		r.valid = 1'b0;
		r.code = '0;
		r.x = x;
		r.y = y;
		x2 = x;
		y2 = y;
		c2 = c;
		del = 1'b0;
		if (c == CH_NL) begin
			r.x = '0;
			r.y = sat16({1'b0, y} + (POS_W+1)'(lp));
		end else if (({1'b0, y} + (POS_W+1)'(cw)) <= (POS_W+1)'(sh)) begin
			if (wrap && (({1'b0, x} + (POS_W+1)'(cw)) > (POS_W+1)'(sw))) begin
				x2 = '0;
				y2 = sat16({1'b0, y} + (POS_W+1)'(lp));
			end
			if (c == CH_BS) begin
				del = 1'b1;
				c2 = CH_SP;
				if (x2 == '0) begin
					x2 = (sw >= 12'(cw)) ? POS_W'(sw - 12'(cw)) : '0;
					y2 = (y2 >= POS_W'(lp)) ? y2 - POS_W'(lp) : '0;
				end else begin
					x2 = (x2 >= POS_W'(cw)) ? x2 - POS_W'(cw) : '0;
				end
			end else if (c == CH_TAB) begin
				x2 = sat16({1'b0, x2} + ((POS_W+1)'(cw) << TAB_CELLS_LOG2));
			end
			r.x = x2;
			r.y = y2;
			if (c2 >= CH_SP && c2 <= CH_TILDE) begin
				r.valid = 1'b1;
				r.code = c2;
				if (!del) begin
					r.x = sat16({1'b0, x2} + (POS_W+1)'(cw));
				end
			end
		end
		return r;
	endfunction

	logic [2:0] func_q;
	logic [7:0] code_q;
	logic wrap_q;
	logic [11:0] px_q;
	logic [11:0] py_q;
	logic [11:0] loc_q;
	logic [POS_W-1:0] cur_x_q;
	logic [POS_W-1:0] cur_y_q;
	logic gv_q;
	logic [7:0] gc_q;
	logic [POS_W-1:0] gx_q;
	logic [POS_W-1:0] gy_q;
	logic [POS_W-1:0] line_q;
	logic [POS_W-1:0] col_q;
	logic out_valid_q;
	logic [7:0] out_code_q;
	logic out_gv_q;
	logic [POS_W-1:0] out_gx_q;
	logic [POS_W-1:0] out_gy_q;
	logic [POS_W-1:0] out_line_q;
	logic [POS_W-1:0] out_col_q;

	logic [2:0] scale;
	logic [CW_W-1:0] cw;
	logic [LP_W-1:0] lp;
	logic [LP_W-1:0] mul_b;
	logic [11+LP_W:0] prod;
	logic [POS_W-1:0] prod_sat;
	draw_t dr;
	logic [POS_W-1:0] nx;
	logic [POS_W-1:0] ny;
	logic ngv;
	logic [7:0] ngc;
	logic [POS_W-1:0] ngx;
	logic [POS_W-1:0] ngy;
	logic div_done;
	logic [POS_W-1:0] quotient;

	always_comb begin
		if (cfg.glyph_scale == 3'd0) begin
			scale = 3'd1;
		end else if (cfg.glyph_scale > 3'(MAX_SCALE)) begin
			scale = 3'(MAX_SCALE);
		end else begin
			scale = cfg.glyph_scale;
		end
	end

	assign cw = CW_W'(scale * CELL_BITS);
	assign lp = LP_W'(cw) + LP_W'(cfg.line_gap);
	assign mul_b = (func_q == FN_SET_LINE) ? lp : LP_W'(cw);
	assign prod = loc_q * mul_b;
	assign prod_sat = (|prod[11+LP_W:POS_W]) ? '1 : prod[POS_W-1:0];

	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		ngv = 1'b0;
		ngc = '0;
		ngx = '0;
		ngy = '0;
		dr = draw_one(POS_W'(px_q), POS_W'(py_q), code_q, 1'b0, cw, lp,
			cfg.screen_width, cfg.screen_height);
		unique case (func_q)
			FN_DRAW_CURSOR: begin
				dr = draw_one(cur_x_q, cur_y_q, code_q, wrap_q, cw, lp,
					cfg.screen_width, cfg.screen_height);
				nx = dr.x;
				ny = dr.y;
				if (dr.valid) begin
					ngv = 1'b1;
					ngc = dr.code;
					ngy = dr.y;
					if (code_q == CH_BS) begin
						ngx = dr.x;
					end else begin
						ngx = (dr.x >= POS_W'(cw)) ? dr.x - POS_W'(cw) : '0;
					end
				end
			end
			FN_DRAW_POINT: begin
				if (dr.valid) begin
					ngv = 1'b1;
					ngc = dr.code;
					ngx = dr.x;
					ngy = dr.y;
				end
			end
			FN_SET_LINE: ny = prod_sat;
			FN_SET_COLUMN: nx = prod_sat;
			FN_HOME: begin
				nx = '0;
				ny = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			code_q <= in_char_code;
			wrap_q <= in_wrap_enable;
			px_q <= in_point_x;
			py_q <= in_point_y;
			loc_q <= in_line_or_column;
		end
		if (cmd.exec) begin
			gv_q <= ngv;
			gc_q <= ngc;
			gx_q <= ngx;
			gy_q <= ngy;
		end
		if (cmd.latch_line) begin
			line_q <= quotient;
		end
		if (cmd.latch_col) begin
			col_q <= quotient;
		end
		if (cmd.push) begin
			out_gv_q <= gv_q;
			out_code_q <= gc_q;
			out_gx_q <= gx_q;
			out_gy_q <= gy_q;
			out_line_q <= line_q;
			out_col_q <= col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	tcc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(cmd.div_sel_x ? cur_x_q : cur_y_q),
		.divisor(cmd.div_sel_x ? LP_W'(cw) : lp),
		.done(div_done),
		.quotient(quotient)
	);

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_glyph_valid = out_gv_q;
	assign out_glyph_code = out_code_q;
	assign out_glyph_x = out_gx_q;
	assign out_glyph_y = out_gy_q;
	assign out_cursor_line = out_line_q;
	assign out_cursor_column = out_col_q;

endmodule

### hdl/tcc_ctrl.sv
`timescale 1ns / 1ps

module tcc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tcc_pkg::sts_t sts,
	output tcc_pkg::cmd_t cmd
);
	import tcc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_DY_GO;
			ST_DY_GO: state_d = ST_DY_RUN;
			ST_DY_RUN: if (sts.div_done) state_d = ST_DX_GO;
			ST_DX_GO: state_d = ST_DX_RUN;
			ST_DX_RUN: if (sts.div_done) state_d = ST_PUSH;
			ST_PUSH: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: cmd.exec = 1'b1;
			ST_DY_GO: cmd.div_start = 1'b1;
			ST_DY_RUN: cmd.latch_line = sts.div_done;
			ST_DX_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_x = 1'b1;
			end
			ST_DX_RUN: begin
				cmd.div_sel_x = 1'b1;
				cmd.latch_col = sts.div_done;
			end
			ST_PUSH: cmd.push = sts.out_free;
			default: ;
		endcase
	end

endmodule

### hdl/text_console_cursor_unit.sv
`timescale 1ns / 1ps

// Cursor unit of a scaled 8x8 text console. Each command beat on the slave side
// yields exactly one result beat on the master side: whether and where a glyph
// cell is painted, plus the cursor line and column after the command. After
// acceptance the cursor step is registered, then the line and column are
// computed one after the other on a single 16-step restoring divider (start,
// 16 steps and the quotient latch each), and the output register is loaded.
// That load waits while the previous result is still held unaccepted in the
// output register. The slave side is ready again in the cycle after the load,
// so no new command is taken before the previous result is loaded. A finished
// result waits in the output register while the next command is accepted.
// The user must write registers through the APB port at byte addresses 0, 4, 8
// and 12 only while the unit is idle; the unit itself does not enforce this.
module text_console_cursor_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// char_code[7:0], wrap_enable[8], point_x[20:9], point_y[32:21],
	// line_or_column[44:33]
	input logic [47:0] s_tdata,
	// func[2:0]
	input logic [2:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// glyph_code[7:0], glyph_x[23:8], glyph_y[39:24], cursor_line[55:40],
	// cursor_column[71:56]
	output logic [71:0] m_tdata,
	// glyph_valid[0]
	output logic [0:0] m_tuser,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tcc_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	reg_idx_t reg_idx;
	logic wr_en;
	logic [7:0] glyph_code;
	logic [15:0] glyph_x;
	logic [15:0] glyph_y;
	logic [15:0] cursor_line;
	logic [15:0] cursor_column;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= 12'd1024;
			cfg_q.screen_height <= 12'd768;
			cfg_q.glyph_scale <= 3'd2;
			cfg_q.line_gap <= 8'd4;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[11:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[11:0];
				REG_GLYPH_SCALE: cfg_q.glyph_scale <= pwdata[2:0];
				REG_LINE_GAP: cfg_q.line_gap <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SCREEN_WIDTH: prdata = 32'(cfg_q.screen_width);
			REG_SCREEN_HEIGHT: prdata = 32'(cfg_q.screen_height);
			REG_GLYPH_SCALE: prdata = 32'(cfg_q.glyph_scale);
			REG_LINE_GAP: prdata = 32'(cfg_q.line_gap);
			default: ;
		endcase
	end

	tcc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	tcc_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.sts(sts),
		.in_func(s_tuser),
		.in_char_code(s_tdata[7:0]),
		.in_wrap_enable(s_tdata[8]),
		.in_point_x(s_tdata[20:9]),
		.in_point_y(s_tdata[32:21]),
		.in_line_or_column(s_tdata[44:33]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_glyph_valid(m_tuser[0]),
		.out_glyph_code(glyph_code),
		.out_glyph_x(glyph_x),
		.out_glyph_y(glyph_y),
		.out_cursor_line(cursor_line),
		.out_cursor_column(cursor_column)
	);

	assign m_tdata = {cursor_column, cursor_line, glyph_y, glyph_x, glyph_code};

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tcc_pkg::*;

	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 315;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] code;
		logic wrap;
		logic [11:0] px;
		logic [11:0] py;
		logic [11:0] loc;
	} console_cmd_t;

	typedef struct packed {
		logic valid;
		logic [7:0] code;
		logic [15:0] gx;
		logic [15:0] gy;
		logic [15:0] line;
		logic [15:0] col;
	} glyph_result_t;

	typedef struct {
		int unsigned x;
		int unsigned y;
		bit valid;
		int unsigned code;
	} cell_step_t;

	class cursor_scoreboard;
		int unsigned scr_w = 1024;
		int unsigned scr_h = 768;
		int unsigned scale = 2;
		int unsigned gap = 4;
		int unsigned cur_x = 0;
		int unsigned cur_y = 0;
		glyph_result_t pending_results[$];
		int errors = 0;
		int beats = 0;

		function int unsigned sat16(int unsigned v);
			return (v > 32'hffff) ? 32'hffff : v;
		endfunction

		function int unsigned cell_width();
			int unsigned s;
			s = (scale == 0) ? 1 : ((scale > MAX_SCALE) ? MAX_SCALE : scale);
			return CELL_BITS * s;
		endfunction

		function int unsigned line_pitch();
			return cell_width() + gap;
		endfunction

		function void set_register(reg_idx_t idx, int unsigned value);
			case (idx)
				REG_SCREEN_WIDTH: scr_w = value & 32'hfff;
				REG_SCREEN_HEIGHT: scr_h = value & 32'hfff;
				REG_GLYPH_SCALE: scale = value & 32'h7;
				REG_LINE_GAP: gap = value & 32'hff;
				default: ;
			endcase
		endfunction

		// one glyph step on a cursor at (x, y); returns the moved cursor
		function cell_step_t step_cell(int unsigned x, int unsigned y, int unsigned c, bit wrap);
			cell_step_t r;
			int unsigned cw;
			int unsigned lp;
			bit erasing;
			cw = cell_width();
			lp = line_pitch();
			erasing = 1'b0;
			r.valid = 1'b0;
			r.code = 0;
			if (c == CH_NL) begin
				r.x = 0;
				r.y = sat16(y + lp);
				return r;
			end
			r.x = x;
			r.y = y;
			if (y + cw > scr_h)
				return r;
			if (wrap && (x + cw > scr_w)) begin
				x = 0;
				y = sat16(y + lp);
			end
			if (c == CH_BS) begin
				erasing = 1'b1;
				c = 32'(CH_SP);
				if (x == 0) begin
					x = (scr_w >= cw) ? scr_w - cw : 0;
					y = (y >= lp) ? y - lp : 0;
				end else begin
					x = (x >= cw) ? x - cw : 0;
				end
			end else if (c == CH_TAB) begin
				x = sat16(x + 4 * cw);
			end
			r.x = x;
			r.y = y;
			if (c < CH_SP || c > CH_TILDE)
				return r;
			r.valid = 1'b1;
			r.code = c;
			if (!erasing)
				r.x = sat16(x + cw);
			return r;
		endfunction

		function void note_command(console_cmd_t c);
			glyph_result_t want;
			cell_step_t r;
			int unsigned cw;
			int unsigned lp;
			cw = cell_width();
			lp = line_pitch();
			want = '0;
			case (c.func)
				FN_DRAW_CURSOR: begin
					r = step_cell(cur_x, cur_y, c.code, c.wrap);
					if (r.valid) begin
						want.valid = 1'b1;
						want.code = 8'(r.code);
						// position before the advance, taken from the saturated cursor
						want.gx = 16'((c.code == CH_BS) ? r.x : ((r.x >= cw) ? r.x - cw : 0));
						want.gy = 16'(r.y);
					end
					cur_x = r.x;
					cur_y = r.y;
				end
				FN_DRAW_POINT: begin
					r = step_cell(c.px, c.py, c.code, 1'b0);
					if (r.valid) begin
						want.valid = 1'b1;
						want.code = 8'(r.code);
						want.gx = 16'(r.x);
						want.gy = 16'(r.y);
					end
				end
				FN_SET_LINE: cur_y = sat16(c.loc * lp);
				FN_SET_COLUMN: cur_x = sat16(c.loc * cw);
				FN_HOME: begin
					cur_x = 0;
					cur_y = 0;
				end
				default: ;
			endcase
			want.line = 16'(cur_y / lp);
			want.col = 16'(cur_x / cw);
			pending_results.push_back(want);
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report_mismatch($sformatf("result beat %0d %s got %0d want %0d",
					beats, name, got, want));
		endtask

		task check_result(glyph_result_t got);
			glyph_result_t want;
			beats++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing pending", beats));
				return;
			end
			want = pending_results.pop_front();
			compare_field("glyph_valid", got.valid, want.valid);
			compare_field("glyph_code", got.code, want.code);
			compare_field("glyph_x", got.gx, want.gx);
			compare_field("glyph_y", got.gy, want.gy);
			compare_field("cursor_line", got.line, want.line);
			compare_field("cursor_column", got.col, want.col);
		endtask

		task close_out();
			if (pending_results.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int src_idle = 0;
	int dst_idle = 0;
	int quiet = 0;
	cursor_scoreboard board;

	text_console_cursor_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(glyph_result_t'({m_tuser[0], m_tdata[7:0], m_tdata[23:8],
				m_tdata[39:24], m_tdata[55:40], m_tdata[71:56]}));
		m_tready <= ($urandom_range(0, 99) >= dst_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic console_cmd_t mk(logic [2:0] func, logic [7:0] code, logic wrap,
		logic [11:0] px, logic [11:0] py, logic [11:0] loc);
		console_cmd_t c;
		c.func = func;
		c.code = code;
		c.wrap = wrap;
		c.px = px;
		c.py = py;
		c.loc = loc;
		return c;
	endfunction

	function automatic logic [7:0] pick_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 66)
			return 8'($urandom_range(CH_SP, CH_TILDE));
		if (roll < 75)
			return CH_NL;
		if (roll < 86)
			return CH_BS;
		if (roll < 92)
			return CH_TAB;
		return 8'($urandom);
	endfunction

	function automatic console_cmd_t random_cmd();
		console_cmd_t c;
		int roll;
		c.code = 8'($urandom);
		c.wrap = 1'($urandom);
		c.px = 12'($urandom);
		c.py = 12'($urandom);
		c.loc = 12'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 58) begin
			c.func = FN_DRAW_CURSOR;
			c.code = pick_char();
		end else if (roll < 68) begin
			c.func = FN_DRAW_POINT;
			c.code = pick_char();
			if ($urandom_range(0, 1)) begin
				c.px = 12'($urandom_range(0, 511));
				c.py = 12'($urandom_range(0, 511));
			end
		end else if (roll < 76) begin
			c.func = FN_SET_LINE;
			if ($urandom_range(0, 4) != 0)
				c.loc = 12'($urandom_range(0, 60));
		end else if (roll < 84) begin
			c.func = FN_SET_COLUMN;
			if ($urandom_range(0, 4) != 0)
				c.loc = 12'($urandom_range(0, 60));
		end else if (roll < 89) begin
			c.func = FN_HOME;
		end else if (roll < 92) begin
			c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		end else begin
			// runs of printable text with wrap to reach the right edge
			c.func = FN_DRAW_CURSOR;
			c.code = 8'($urandom_range(CH_SP, CH_TILDE));
			c.wrap = 1'b1;
		end
		return c;
	endfunction

	task automatic send_cmd(console_cmd_t c);
		int gaps;
		gaps = 0;
		while ($urandom_range(0, 99) < src_idle && gaps < 40)
			gaps++;
		if (gaps > 0) begin
			s_tvalid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, c.loc, c.py, c.px, c.wrap, c.code};
		s_tuser <= c.func;
		do @(posedge clk); while (!s_tready);
		board.note_command(c);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending_results.size() != 0);
	endtask

	task automatic apb_write(reg_idx_t idx, int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_screen(int unsigned w, int unsigned h, int unsigned s, int unsigned g);
		apb_write(REG_SCREEN_WIDTH, w);
		apb_write(REG_SCREEN_HEIGHT, h);
		apb_write(REG_GLYPH_SCALE, s);
		apb_write(REG_LINE_GAP, g);
	endtask

	task automatic run_directed();
		send_cmd(mk(FN_DRAW_CURSOR, 8'd65, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, CH_SP, 1'b1, 12'hfff, 12'hfff, 12'hfff));
		send_cmd(mk(FN_DRAW_CURSOR, CH_TILDE, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, 8'd127, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, 8'd255, 1'b1, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, 8'd0, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, CH_TAB, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, CH_BS, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, CH_NL, 1'b0, 12'd0, 12'd0, 12'd0));
		// backspace at column 0 goes back to the previous line
		send_cmd(mk(FN_DRAW_CURSOR, CH_BS, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_HOME, 8'd65, 1'b1, 12'hfff, 12'hfff, 12'hfff));
		// backspace on the top line clamps y
		send_cmd(mk(FN_DRAW_CURSOR, CH_BS, 1'b1, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_POINT, 8'd65, 1'b1, 12'hfff, 12'hfff, 12'd0));
		send_cmd(mk(FN_DRAW_POINT, 8'd90, 1'b0, 12'd0, 12'd0, 12'hfff));
		send_cmd(mk(FN_DRAW_POINT, CH_BS, 1'b0, 12'd0, 12'd100, 12'd0));
		send_cmd(mk(FN_DRAW_POINT, CH_NL, 1'b0, 12'd300, 12'd200, 12'd0));
		send_cmd(mk(FN_SET_LINE, 8'd65, 1'b0, 12'd0, 12'd0, 12'hfff));
		send_cmd(mk(FN_DRAW_CURSOR, 8'd66, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_SET_COLUMN, 8'd0, 1'b1, 12'hfff, 12'hfff, 12'hfff));
		send_cmd(mk(FN_SET_LINE, 8'd0, 1'b0, 12'd0, 12'd0, 12'd0));
		// advance past the top of the 16-bit range saturates
		send_cmd(mk(FN_DRAW_CURSOR, 8'd68, 1'b0, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_DRAW_CURSOR, 8'd67, 1'b1, 12'd0, 12'd0, 12'd0));
		send_cmd(mk(FN_SPARE_LO, 8'd65, 1'b1, 12'hfff, 12'hfff, 12'hfff));
		send_cmd(mk(FN_SPARE_HI, CH_BS, 1'b0, 12'd5, 12'd5, 12'd5));
		send_cmd(mk(FN_HOME, 8'd255, 1'b0, 12'd0, 12'd0, 12'd0));
	endtask

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase / 2)
				0: begin
					src_idle = 30;
					dst_idle = 62;
				end
				1: begin
					src_idle = 62;
					dst_idle = 30;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			if (phase != 0) begin
				drain_results();
				repeat (4) @(posedge clk);
			end
			case (phase)
				0: run_directed();
				1: set_screen(8, 8, 0, 0);
				2: set_screen(4095, 4095, 7, 255);
				3: set_screen($urandom_range(8, 400), $urandom_range(8, 400),
					$urandom_range(0, 7), $urandom_range(0, 255));
				4: set_screen(40, 300, 7, 0);
				default: set_screen($urandom_range(8, 4095), $urandom_range(8, 4095),
					$urandom_range(0, 7), $urandom_range(0, 30));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == 150)
					drain_results();
				send_cmd(random_cmd());
			end
		end
		drain_results();
		repeat (50) @(posedge clk);
		board.close_out();
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
